### rtl/bsu_pkg.sv
// Package for the backslash escape decoder.
// Holds the scan states, character codes, result plan type and the hex and UTF-8 helpers.
// Has no dependencies of its own.
package bsu_pkg;

   localparam int unsigned PEND_DEPTH = 8;

   localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0]  CHAR_U         = 8'h75;
   localparam logic [7:0]  CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0]  CHAR_RBRACE    = 8'h7D;
   localparam logic [23:0] MAX_CODE       = 24'h10FFFF;

   typedef enum logic [3:0] {
      ST_PLAIN  = 4'd0,
      ST_ESC    = 4'd1,
      ST_U      = 4'd2,
      ST_U1     = 4'd3,
      ST_BRACE  = 4'd4,
      ST_U2     = 4'd5,
      ST_B1     = 4'd6,
      ST_U3     = 4'd7,
      ST_B2     = 4'd8,
      ST_B3     = 4'd9,
      ST_B4     = 4'd10,
      ST_B5     = 4'd11,
      ST_B6     = 4'd12
   } scan_state_type;

   typedef logic [PEND_DEPTH-1:0][7:0] pend_type;
   typedef logic [3:0][7:0]            tail_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic [2:0] len;
      tail_type   bytes;
   } utf8_type;

   // Everything the emitter needs to replay one item's results.
   typedef struct packed {
      pend_type   pend;
      logic [3:0] flush_n;
      logic [2:0] tail_n;
      tail_type   tail;
      logic       at_end;
      logic       no_data;
   } plan_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.val = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.val = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.val = 4'(c - 8'h57);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [23:0] v);
      utf8_type r;
      r.bytes = '0;
      if (v < 24'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = v[7:0];
      end else if (v < 24'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, v[10:6]};
         r.bytes[1] = {2'b10, v[5:0]};
      end else if (v < 24'h10000) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, v[15:12]};
         r.bytes[1] = {2'b10, v[11:6]};
         r.bytes[2] = {2'b10, v[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, v[20:18]};
         r.bytes[1] = {2'b10, v[17:12]};
         r.bytes[2] = {2'b10, v[11:6]};
         r.bytes[3] = {2'b10, v[5:0]};
      end
      return r;
   endfunction

endpackage

### rtl/backslash_unicode_unescape_core.sv
// Top level of the backslash escape decoder with Unicode escapes to UTF-8.
// Holds the input register and instantiates bsu_scan and bsu_emit; depends on bsu_pkg.
//
// Each accepted item passes through an input register into the scanner, which
// decides its results combinationally and hands them to the result sequencer.
// Plain bytes and items that only extend an escape go through at one item per
// cycle while the result port does not stall. An item that gives several result
// bytes (a UTF-8 sequence of up to four bytes, or a failed escape replayed with up
// to nine bytes) holds back the next item with results of its own until its last
// byte is sent, since the sequencer sends one byte a cycle on the result port.
// An item passes the input register, then the sequencer's plan register, before its first result byte.
module backslash_unicode_unescape_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import bsu_pkg::*;

   logic       a_valid_ff, a_valid_in;
   logic       a_mode_ff;
   logic [7:0] a_byte_ff;
   logic       req_take;
   logic       go;
   logic       needs_emit;
   logic       emit_free;
   logic [3:0] pend_cnt;
   plan_type   plan;

   assign go        = a_valid_ff && (!needs_emit || emit_free);
   assign req_stall = a_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (go) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_mode_ff <= req_mode;
         a_byte_ff <= req_in_byte;
      end
   end

   bsu_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .item_mode  (a_mode_ff),
      .item_byte  (a_byte_ff),
      .plan       (plan),
      .needs_emit (needs_emit),
      .pend_cnt   (pend_cnt)
   );

   bsu_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (go && needs_emit),
      .plan           (plan),
      .free           (emit_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_end) |-> rsp_run_last)
      else $error("End of string flagged on a result that is not the last of its item.");

   a_empty_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_string_end)
      else $error("Empty result outside an end-of-string item.");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt <= 4'(PEND_DEPTH))
      else $error("Pending byte count beyond the buffer depth.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (go && needs_emit && rsp_valid) |-> (rsp_run_last && !rsp_stall))
      else $error("Sequencer loaded while its current item still has bytes to send.");

endmodule

### rtl/bsu_scan.sv
// Escape scanner: holds the scan state, code value and pending raw bytes.
// Turns one item into a state update and a plan of result bytes.
// Depends on bsu_pkg.
module bsu_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic              item_mode,
   input  logic [7:0]        item_byte,
   output bsu_pkg::plan_type plan,
   output logic              needs_emit,
   output logic [3:0]        pend_cnt
);
   import bsu_pkg::*;

   scan_state_type st_ff, st_in;
   logic [23:0]    code_ff, code_in;
   logic [3:0]     cnt_ff, cnt_in;
   pend_type       pend_ff, pend_in;
   hex_type        hx;
   logic [23:0]    shifted;
   logic [23:0]    enc_val;
   utf8_type       enc;
   scan_state_type hnext;

   function automatic scan_state_type hex_next(input scan_state_type s);
      scan_state_type r;
      case (s)
         ST_U:     r = ST_U1;
         ST_U1:    r = ST_U2;
         ST_BRACE: r = ST_B1;
         ST_U2:    r = ST_U3;
         ST_B1:    r = ST_B2;
         ST_B2:    r = ST_B3;
         ST_B3:    r = ST_B4;
         ST_B4:    r = ST_B5;
         ST_B5:    r = ST_B6;
         default:  r = ST_PLAIN;
      endcase
      return r;
   endfunction

   assign hx      = hex_decode(item_byte);
   assign shifted = {code_ff[19:0], hx.val};
   assign hnext   = hex_next(st_ff);
   assign enc_val = (st_ff == ST_U3 && hx.ok) ? shifted : code_ff;
   assign enc     = utf8_encode(enc_val);

   always_comb begin
      st_in        = st_ff;
      code_in      = code_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      plan.pend    = pend_ff;
      plan.flush_n = 4'd0;
      plan.tail_n  = 3'd0;
      plan.tail    = '0;
      plan.at_end  = 1'b0;
      plan.no_data = 1'b0;
      if (item_mode) begin
         plan.flush_n = cnt_ff;
         plan.no_data = (cnt_ff == 4'd0);
         plan.at_end  = 1'b1;
         st_in        = ST_PLAIN;
         code_in      = '0;
         cnt_in       = 4'd0;
      end else begin
         unique case (st_ff)
            ST_PLAIN: begin
               if (item_byte == CHAR_BACKSLASH) begin
                  st_in  = ST_ESC;
                  cnt_in = 4'd0;
               end else begin
                  plan.tail_n  = 3'd1;
                  plan.tail[0] = item_byte;
               end
            end
            ST_ESC: begin
               if (item_byte == CHAR_U) begin
                  st_in      = ST_U;
                  code_in    = '0;
                  pend_in[0] = item_byte;
                  cnt_in     = 4'd1;
               end else begin
                  plan.tail_n  = 3'd1;
                  plan.tail[0] = item_byte;
                  st_in        = ST_PLAIN;
               end
            end
            default: begin
               if (item_byte == CHAR_BACKSLASH) begin
                  plan.flush_n = cnt_ff;
                  cnt_in       = 4'd0;
                  st_in        = ST_ESC;
               end else if (hx.ok && st_ff == ST_U3) begin
                  code_in     = shifted;
                  cnt_in      = 4'd0;
                  plan.tail_n = enc.len;
                  plan.tail   = enc.bytes;
                  st_in       = ST_PLAIN;
               end else if (hx.ok && hnext != ST_PLAIN) begin
                  code_in = shifted;
                  if (cnt_ff < 4'(PEND_DEPTH)) begin
                     pend_in[cnt_ff[2:0]] = item_byte;
                     cnt_in               = cnt_ff + 4'd1;
                  end
                  st_in = hnext;
               end else if (item_byte == CHAR_RBRACE && st_ff >= ST_B1 && st_ff <= ST_B6) begin
                  if (code_ff <= MAX_CODE) begin
                     plan.tail_n = enc.len;
                     plan.tail   = enc.bytes;
                  end else begin
                     plan.flush_n = cnt_ff;
                     plan.tail_n  = 3'd1;
                     plan.tail[0] = item_byte;
                  end
                  cnt_in = 4'd0;
                  st_in  = ST_PLAIN;
               end else if (item_byte == CHAR_LBRACE && st_ff == ST_U) begin
                  if (cnt_ff < 4'(PEND_DEPTH)) begin
                     pend_in[cnt_ff[2:0]] = item_byte;
                     cnt_in               = cnt_ff + 4'd1;
                  end
                  st_in = ST_BRACE;
               end else begin
                  plan.flush_n = cnt_ff;
                  plan.tail_n  = 3'd1;
                  plan.tail[0] = item_byte;
                  cnt_in       = 4'd0;
                  st_in        = ST_PLAIN;
               end
            end
         endcase
      end
   end

   assign needs_emit = plan.no_data || (plan.flush_n != 4'd0) || (plan.tail_n != 3'd0);
   assign pend_cnt   = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_PLAIN;
         code_ff <= '0;
         cnt_ff  <= 4'd0;
      end else if (go) begin
         st_ff   <= st_in;
         code_ff <= code_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         pend_ff <= pend_in;
      end
   end

endmodule

### rtl/bsu_emit.sv
// Result sequencer: holds one item's plan and sends its bytes one per cycle unless stalled.
// Replayed pending bytes come first, then the decoded or breaking bytes.
// Depends on bsu_pkg.
module bsu_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bsu_pkg::plan_type plan,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_run_last,
   output logic              rsp_string_end
);
   import bsu_pkg::*;

   plan_type   plan_ff;
   logic       busy_ff, busy_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] total_ff, total_in;
   logic       last;
   logic [3:0] tail_pos;

   assign total_in = plan.no_data ? 4'd1 : plan.flush_n + {1'b0, plan.tail_n};
   assign last     = (idx_ff == total_ff - 4'd1);
   assign free     = !busy_ff || (last && !rsp_stall);
   assign tail_pos = idx_ff - plan_ff.flush_n;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end else if (busy_ff && !rsp_stall) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         plan_ff  <= plan;
         total_ff <= total_in;
      end
   end

   always_comb begin
      if (plan_ff.no_data) begin
         rsp_out_byte = 8'd0;
      end else if (idx_ff < plan_ff.flush_n) begin
         rsp_out_byte = plan_ff.pend[idx_ff[2:0]];
      end else begin
         rsp_out_byte = plan_ff.tail[tail_pos[1:0]];
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_byte_valid = !plan_ff.no_data;
   assign rsp_run_last   = last;
   assign rsp_string_end = plan_ff.at_end && last;

endmodule

### verif/backslash_unicode_unescape_core_test.sv
`timescale 1ns / 1ps
// Testbench for backslash_unicode_unescape_core: directed escapes, then random byte streams.
// Predicts each decoded byte in its own scanner model and checks every result item in order.
// Depends on bsu_pkg and the block's RTL.
module backslash_unicode_unescape_core_test;
   import bsu_pkg::*;

   localparam logic MODE_DATA     = 1'b0;
   localparam logic MODE_END      = 1'b1;
   localparam int   IDLE_PERCENT  = 11;
   localparam int   SETTLE_CYCLES = 16;
   localparam int   QUIET_LIMIT   = 1000;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       fin;
   } decoded_byte_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_mode;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_string_end;

   decoded_byte_type expected_bytes[$];
   decoded_byte_type want;
   scan_state_type   scan_st;
   logic [23:0]      code_acc;
   logic [7:0]       held [PEND_DEPTH];
   int               held_n;
   int               step_n;
   int               errors;
   int               sent_items;
   int               quiet_cycles;
   bit               idle_on;

   backslash_unicode_unescape_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_run_last(rsp_run_last),
      .rsp_string_end(rsp_string_end)
   );

   always #10 clock = ~clock;

   function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
         v = c[3:0];
         return 1'b1;
      end
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         v = 4'(c[3:0] + 4'd9);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic scan_state_type digit_state_after(input scan_state_type s);
      case (s)
         ST_U:     return ST_U1;
         ST_U1:    return ST_U2;
         ST_U2:    return ST_U3;
         ST_BRACE: return ST_B1;
         ST_B1:    return ST_B2;
         ST_B2:    return ST_B3;
         ST_B3:    return ST_B4;
         ST_B4:    return ST_B5;
         ST_B5:    return ST_B6;
         default:  return ST_PLAIN;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + 8'(v);
      end
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v - 4'd10);
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic ok);
      decoded_byte_type e;
      e.data  = ok ? b : 8'h00;
      e.valid = ok;
      e.last  = 1'b0;
      e.fin   = 1'b0;
      expected_bytes.insert(expected_bytes.size(), e);
      step_n++;
   endtask

   task automatic replay_held();
      for (int i = 0; i < held_n; i++) begin
         put_byte(held[i], 1'b1);
      end
      held_n = 0;
   endtask

   task automatic hold_byte(input logic [7:0] b);
      if (held_n < PEND_DEPTH) begin
         held[held_n] = b;
         held_n++;
      end
   endtask

   task automatic put_code_point(input logic [23:0] cp);
      if (cp < 24'h80) begin
         put_byte(cp[7:0], 1'b1);
      end else if (cp < 24'h800) begin
         put_byte({3'b110, cp[10:6]}, 1'b1);
         put_byte({2'b10, cp[5:0]}, 1'b1);
      end else if (cp < 24'h10000) begin
         put_byte({4'b1110, cp[15:12]}, 1'b1);
         put_byte({2'b10, cp[11:6]}, 1'b1);
         put_byte({2'b10, cp[5:0]}, 1'b1);
      end else begin
         put_byte({5'b11110, cp[20:18]}, 1'b1);
         put_byte({2'b10, cp[17:12]}, 1'b1);
         put_byte({2'b10, cp[11:6]}, 1'b1);
         put_byte({2'b10, cp[5:0]}, 1'b1);
      end
   endtask

   task automatic predict_decoded(input logic m, input logic [7:0] c);
      logic [3:0]     v;
      bit             hx;
      scan_state_type nx;
      step_n = 0;
      if (m == MODE_END) begin
         replay_held();
         if (step_n == 0) begin
            put_byte(8'h00, 1'b0);
         end
         expected_bytes[$].last = 1'b1;
         expected_bytes[$].fin  = 1'b1;
         scan_st  = ST_PLAIN;
         code_acc = '0;
         held_n   = 0;
         return;
      end
      hx = hex_digit(c, v);
      nx = digit_state_after(scan_st);
      if (scan_st == ST_PLAIN) begin
         if (c == CHAR_BACKSLASH) begin
            scan_st = ST_ESC;
            held_n  = 0;
         end else begin
            put_byte(c, 1'b1);
         end
      end else if (scan_st == ST_ESC) begin
         if (c == CHAR_U) begin
            scan_st  = ST_U;
            code_acc = '0;
            held_n   = 0;
            hold_byte(c);
         end else begin
            put_byte(c, 1'b1);
            scan_st = ST_PLAIN;
         end
      end else if (c == CHAR_BACKSLASH) begin
         replay_held();
         scan_st = ST_ESC;
      end else if (hx && scan_st == ST_U3) begin
         code_acc = {code_acc[19:0], v};
         held_n   = 0;
         put_code_point(code_acc);
         scan_st = ST_PLAIN;
      end else if (hx && nx != ST_PLAIN) begin
         code_acc = {code_acc[19:0], v};
         hold_byte(c);
         scan_st = nx;
      end else if (c == CHAR_RBRACE && scan_st >= ST_B1 && scan_st <= ST_B6) begin
         if (code_acc <= MAX_CODE) begin
            held_n = 0;
            put_code_point(code_acc);
         end else begin
            replay_held();
            put_byte(c, 1'b1);
         end
         scan_st = ST_PLAIN;
      end else if (c == CHAR_LBRACE && scan_st == ST_U) begin
         hold_byte(c);
         scan_st = ST_BRACE;
      end else begin
         replay_held();
         put_byte(c, 1'b1);
         scan_st = ST_PLAIN;
      end
      if (step_n > 0) begin
         expected_bytes[$].last = 1'b1;
      end
   endtask

   task automatic send_item(input logic m, input logic [7:0] b);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_mode    = m;
      req_in_byte = b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_decoded(m, b);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(MODE_DATA, s[i]);
      end
   endtask

   task automatic wait_for_results(input int extra);
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bytes.size() > 0) begin
         @(posedge clock);
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic send_digits(input int count, input bit small_lead);
      logic [3:0] v;
      for (int i = 0; i < count; i++) begin
         v = 4'($urandom_range(15));
         if (i == 0 && small_lead) begin
            v = 4'($urandom_range(1));
         end
         send_item(MODE_DATA, hex_char(v));
      end
   endtask

   task automatic send_unicode_escape();
      int ndig;
      send_item(MODE_DATA, CHAR_BACKSLASH);
      send_item(MODE_DATA, CHAR_U);
      if ($urandom_range(1)) begin
         if ($urandom_range(9) == 0) begin
            send_digits(3, 1'b0);
            send_item(MODE_DATA, CHAR_RBRACE);
         end else begin
            send_digits(4, 1'b0);
         end
      end else begin
         send_item(MODE_DATA, CHAR_LBRACE);
         ndig = ($urandom_range(11) == 0) ? 7 : $urandom_range(1, 6);
         send_digits(ndig, ndig >= 6 && $urandom_range(1));
         send_item(MODE_DATA, CHAR_RBRACE);
      end
   endtask

   task automatic send_broken_escape();
      send_item(MODE_DATA, CHAR_BACKSLASH);
      send_item(MODE_DATA, CHAR_U);
      if ($urandom_range(1)) begin
         send_item(MODE_DATA, CHAR_LBRACE);
         send_digits($urandom_range(5), 1'b0);
      end else begin
         send_digits($urandom_range(3), 1'b0);
      end
      case ($urandom_range(3))
         0:       send_item(MODE_DATA, CHAR_BACKSLASH);
         1:       send_item(MODE_END, 8'($urandom_range(255)));
         default: send_item(MODE_DATA, 8'($urandom_range(255)));
      endcase
   endtask

   task automatic send_random_stream(input int count);
      int target;
      int pick;
      target = sent_items + count;
      while (sent_items < target) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_item(MODE_DATA, 8'($urandom_range(255)));
         end else if (pick < 70) begin
            send_unicode_escape();
         end else if (pick < 85) begin
            send_broken_escape();
         end else if (pick < 93) begin
            send_item(MODE_DATA, CHAR_BACKSLASH);
            send_item(MODE_DATA, 8'($urandom_range(255)));
         end else begin
            send_item(MODE_END, 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_plain_bytes();
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_DATA, 8'hFF);
      send_item(MODE_DATA, "A");
      send_item(MODE_END, 8'hA5);
   endtask

   task automatic test_brace_after_three_digits();
      send_text("\\uAbC}");
   endtask

   task automatic test_code_above_max();
      send_text("\\u{110000}");
   endtask

   task automatic test_escape_restart_and_end();
      send_text("\\u1\\u{");
      send_item(MODE_END, 8'h00);
      send_text("\\");
      send_item(MODE_END, 8'hFF);
      wait_for_results(4);
   endtask

   task automatic test_unbroken_stream();
      idle_on = 1'b0;
      send_random_stream(150);
      idle_on = 1'b1;
   endtask

   task automatic test_random_stream();
      send_random_stream(250);
   endtask

   always @(negedge clock) begin
      rsp_stall = idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result item: out_byte %0h", rsp_out_byte);
            errors++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               errors++;
            end
            if (rsp_byte_valid !== want.valid) begin
               $error("byte_valid: expected %0b, got %0b", want.valid, rsp_byte_valid);
               errors++;
            end
            if (rsp_run_last !== want.last) begin
               $error("run_last: expected %0b, got %0b", want.last, rsp_run_last);
               errors++;
            end
            if (rsp_string_end !== want.fin) begin
               $error("string_end: expected %0b, got %0b", want.fin, rsp_string_end);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_DATA;
      req_in_byte  = 8'h00;
      rsp_stall    = 1'b0;
      idle_on      = 1'b1;
      errors       = 0;
      sent_items   = 0;
      quiet_cycles = 0;
      scan_st      = ST_PLAIN;
      code_acc     = '0;
      held_n       = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_plain_bytes();
      test_brace_after_three_digits();
      test_code_above_max();
      test_escape_restart_and_end();
      test_unbroken_stream();
      test_random_stream();

      wait_for_results(SETTLE_CYCLES);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
